@@ rtl/mbf_pkg.sv @@
// Package for the MBF float convert/compare unit: operation codes, result
// layout and format constants. No dependencies.
package mbf_pkg;

  typedef enum logic [3:0] {
    OP_NEG      = 4'd0,
    OP_ABS      = 4'd1,
    OP_SIGN     = 4'd2,
    OP_COMPARE  = 4'd3,
    OP_FROM_I16 = 4'd4,
    OP_FROM_U16 = 4'd5,
    OP_FROM_I32 = 4'd6,
    OP_TO_I16   = 4'd7,
    OP_TO_I32   = 4'd8,
    OP_FLOOR    = 4'd9
  } op_t;

  localparam logic [7:0] EXP_BIAS = 8'd129;

  typedef struct packed {
    logic [31:0] float_result;
    logic [31:0] int_result;
    logic [1:0]  order_result;
    logic        overflow_flag;
  } result_t;

  // Position of the leading one (word nonzero).
  function automatic logic [4:0] lead_one(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

@@ rtl/mbf_alu.sv @@
// Combinational datapath of the MBF unit: all ten operations and result select.
// Depends on mbf_pkg.
module mbf_alu (
  input  logic [3:0]       operation,
  input  logic [31:0]      operand_a,
  input  logic [31:0]      operand_b,
  input  logic [31:0]      int_operand,
  output mbf_pkg::result_t res
);

  logic [7:0]  ea, eb;
  logic        na;
  logic [23:0] ma, mb;
  logic [1:0]  sa, sb, cmp;

  assign ea = operand_a[31:24];
  assign eb = operand_b[31:24];
  assign na = operand_a[23];
  assign ma = {1'b1, operand_a[22:0]};
  assign mb = {1'b1, operand_b[22:0]};
  assign sa = (ea == 8'd0) ? 2'b00 : (na ? 2'b11 : 2'b01);
  assign sb = (eb == 8'd0) ? 2'b00 : (operand_b[23] ? 2'b11 : 2'b01);

  logic gt_mag;
  always_comb begin
    gt_mag = (ea != eb) ? (ea > eb) : (ma > mb);
    if (sa != sb) cmp = ($signed(sa) > $signed(sb)) ? 2'b01 : 2'b11;
    else if (sa == 2'b00) cmp = 2'b00;
    else if (ea == eb && ma == mb) cmp = 2'b00;
    else cmp = (gt_mag ^ (sa == 2'b11)) ? 2'b01 : 2'b11;
  end

  // integer to float
  logic        fneg;
  logic [31:0] fmag, fnorm;
  logic [4:0]  fp;
  logic [31:0] from_f;
  always_comb begin
    fneg = 1'b0;
    fmag = int_operand;
    case (operation)
      mbf_pkg::OP_FROM_I16: begin
        fneg = int_operand[15];
        fmag = {16'd0, int_operand[15] ? 16'(-int_operand[15:0]) : int_operand[15:0]};
      end
      mbf_pkg::OP_FROM_U16: fmag = {16'd0, int_operand[15:0]};
      default: begin
        fneg = int_operand[31];
        fmag = int_operand[31] ? 32'(-int_operand) : int_operand;
      end
    endcase
    fp = mbf_pkg::lead_one(fmag);
    fnorm = fmag << (5'd31 - fp);
    from_f = (fmag == 32'd0) ? 32'd0 :
             {8'(mbf_pkg::EXP_BIAS + 8'(fp)), fneg, fnorm[30:8]};
  end

  // float to integer
  logic [7:0]  sh;
  logic [62:0] wide;
  logic [31:0] mag, to16, to32;
  logic        ov16, ov32;
  always_comb begin
    sh   = ea - mbf_pkg::EXP_BIAS;
    wide = {39'd0, ma} << sh[4:0];
    mag  = wide[54:23];
    ov16 = (ea > 8'(mbf_pkg::EXP_BIAS + 8'd14));
    ov32 = (ea > 8'(mbf_pkg::EXP_BIAS + 8'd30));
    if (ea == 8'd0 || ea < mbf_pkg::EXP_BIAS) begin
      to16 = 32'd0; to32 = 32'd0;
    end else begin
      to32 = na ? 32'(-mag) : mag;
      to16 = {{16{to32[15]}}, to32[15:0]};
    end
    if (ov16) to16 = na ? 32'hFFFF8000 : 32'd32767;
    if (ov32) to32 = na ? 32'h80000000 : 32'h7FFFFFFF;
  end

  // floor
  logic [23:0] fmask, mtr;
  logic [24:0] msum;
  logic [31:0] floor_f;
  logic [7:0]  fe;
  always_comb begin
    fmask = 24'hFFFFFF >> (5'd1 + sh[4:0]);
    mtr = ma & ~fmask;
    msum = {1'b0, mtr};
    fe = ea;
    if (na && (ma & fmask) != 24'd0) msum = {1'b0, mtr} + {1'b0, fmask} + 25'd1;
    if (msum[24]) begin
      msum = msum >> 1;
      fe = ea + 8'd1;
    end
    if (ea == 8'd0) floor_f = 32'd0;
    else if (ea < mbf_pkg::EXP_BIAS) floor_f = na ? {mbf_pkg::EXP_BIAS, 1'b1, 23'd0} : 32'd0;
    else if (ea >= 8'(mbf_pkg::EXP_BIAS + 8'd24)) floor_f = operand_a;
    else if (fe == 8'd0) floor_f = 32'd0;
    else floor_f = {fe, na, msum[22:0]};
  end

  always_comb begin
    res = '0;
    case (operation)
      mbf_pkg::OP_NEG:      res.float_result = (ea == 8'd0) ? operand_a
                                               : (operand_a ^ 32'h00800000);
      mbf_pkg::OP_ABS:      res.float_result = operand_a & ~32'h00800000;
      mbf_pkg::OP_SIGN:     res.order_result = sa;
      mbf_pkg::OP_COMPARE:  res.order_result = cmp;
      mbf_pkg::OP_FROM_I16,
      mbf_pkg::OP_FROM_U16,
      mbf_pkg::OP_FROM_I32: res.float_result = from_f;
      mbf_pkg::OP_TO_I16: begin
        res.int_result = to16; res.overflow_flag = ov16;
      end
      mbf_pkg::OP_TO_I32: begin
        res.int_result = to32; res.overflow_flag = ov32;
      end
      mbf_pkg::OP_FLOOR:    res.float_result = floor_f;
      default: ;
    endcase
  end

endmodule

@@ rtl/mbf_float_convert_compare_unit.sv @@
// Top level of the MBF float convert/compare unit: input register, datapath,
// output register. Depends on mbf_pkg and mbf_alu.
//
// One item per cycle while out_tready is high. The input register feeds the
// single-pass datapath and the result register; out_tvalid rises once the
// item has moved from the input register into the result register. The
// result register holds while out_tready is low; in_tready follows the
// state of both registers so the pipeline never drops or repeats a transfer.
module mbf_float_convert_compare_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[3:0], operand_a[35:4], operand_b[67:36], int_operand[99:68]
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // float_result[31:0], int_result[63:32], order_result[65:64],
  // overflow_flag[66]
  output logic [71:0]  out_tdata
);

  logic [103:0] in_data_r;
  logic         in_vld_r, out_vld_r;
  logic [66:0]  out_data_r;
  mbf_pkg::result_t res;
  logic         adv;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;

  mbf_alu u_alu (
    .operation   (in_data_r[3:0]),
    .operand_a   (in_data_r[35:4]),
    .operand_b   (in_data_r[67:36]),
    .int_operand (in_data_r[99:68]),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (adv) out_vld_r <= in_vld_r;
    end
    if (in_tready && in_tvalid) in_data_r <= in_tdata;
    if (adv && in_vld_r) out_data_r <= {res.overflow_flag, res.order_result,
                                        res.int_result, res.float_result};
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_data_r};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r)
    else $error("input stage lost item");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_tready)
    else $error("empty stage not ready");

endmodule
